### rtl/assert_macros.svh
// Assertion macros used by the sorter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk, quiet while aresetn is low.
`define AIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same check, held off during the cycle that follows reset release too.
`define AIS_ASSERT_PAST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn || !$past(aresetn)) (prop)) \
        else $error(msg);

`endif

### rtl/ais_pkg.sv
// Shared types and constants of the ascending integer sorter.
package ais_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;  // place the incoming value at its sorted position
        logic shift;   // move every entry one cell towards the output
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

### rtl/ais_cell.sv
// One cell of the sorting chain: holds one value and its valid bit.
module ais_cell
    import ais_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  data_t      ins_value,
    input  logic       prev_gt,
    input  data_t      prev_data,
    input  logic       prev_valid,
    input  data_t      next_data,
    input  logic       next_valid,
    output data_t      data_o,
    output logic       valid_o,
    output logic       gt_o
);

    data_t data_reg, data_next;
    logic  valid_reg, valid_next;

    // Empty cells count as greater, so the gt flags form one step along the chain.
    assign gt_o = !valid_reg || (data_reg > ins_value);

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.insert) begin
            if (gt_o) begin
                data_next = prev_gt ? prev_data : ins_value;
            end
            valid_next = valid_reg || prev_valid;
        end else if (ctrl.shift) begin
            data_next  = next_data;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o  = data_reg;
    assign valid_o = valid_reg;

endmodule

### rtl/ascending_integer_sorter.sv
// Top level of the ascending integer sorter: control and the chain of cells.
//
// Usage
//   Input channel (s_*): one request per list element, s_is_final marks the
//   last element. Requests are taken one per cycle while the block is loading.
//   Result channel (m_*): after the final request the list comes out in
//   ascending signed order, one request per cycle while m_ready is high;
//   m_run_end marks the last one, m_overflow is set on every result of a
//   run in which more than DEPTH elements arrived (the extras are dropped).
// Timing
//   Each element is placed at its sorted position in the cell chain in the
//   cycle it is accepted. The first result is valid the cycle after the
//   final request. A new list is taken only after the whole run has
//   drained; s_ready is low while draining.
// Reset
//   aresetn (synchronous, active low) empties the chain, clears the overflow
//   flag and returns to loading.
// Stall
//   A low m_ready simply holds the chain; the head cell drives the payload
//   and stays put until taken.
module ascending_integer_sorter
    import ais_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  data_t s_item_value,
    input  logic  s_is_final,
    output logic  m_valid,
    input  logic  m_ready,
    output data_t m_sorted_value,
    output logic  m_run_end,
    output logic  m_overflow
);

    state_t     state_reg, state_next;
    logic       overflow_reg, overflow_next;
    cell_ctrl_t ctrl;

    data_t      cell_data  [DEPTH];
    logic       cell_valid [DEPTH];
    logic       cell_gt    [DEPTH];

    logic s_fire, m_fire, full;

    // Chain is filled from the head, so the tail valid bit means full.
    assign full    = cell_valid[DEPTH-1];
    assign s_ready = (state_reg == ST_LOAD);
    assign s_fire  = s_valid && s_ready;

    // Head cell holds the smallest element.
    assign m_valid        = (state_reg == ST_DRAIN) && cell_valid[0];
    assign m_sorted_value = cell_data[0];
    assign m_run_end      = cell_valid[0] && !cell_valid[1];
    assign m_overflow     = overflow_reg;
    assign m_fire         = m_valid && m_ready;

    // Insert only with room; a dropped element still closes the list.
    assign ctrl.insert = s_fire && !full;
    assign ctrl.shift  = m_fire;

    always_comb begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (full) begin
                        overflow_next = 1'b1;
                    end
                    if (s_is_final) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (m_fire && m_run_end) begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default: begin
                state_next    = ST_LOAD;
                overflow_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

    // Chain: each cell sees its lower neighbour for insertion and its upper
    // neighbour for draining. The head treats its missing neighbour as a
    // valid, not-greater entry; the tail sees an empty upper neighbour.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic  prev_gt, prev_valid, next_valid;
        data_t prev_data, next_data;

        if (i == 0) begin : g_head
            assign prev_gt    = 1'b0;
            assign prev_valid = 1'b1;
            assign prev_data  = s_item_value;
        end else begin : g_body
            assign prev_gt    = cell_gt[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_data  = cell_data[i-1];
        end

        if (i == DEPTH-1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_data  = s_item_value;
        end else begin : g_inner
            assign next_valid = cell_valid[i+1];
            assign next_data  = cell_data[i+1];
        end

        ais_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .ins_value  (s_item_value),
            .prev_gt    (prev_gt),
            .prev_data  (prev_data),
            .prev_valid (prev_valid),
            .next_data  (next_data),
            .next_valid (next_valid),
            .data_o     (cell_data[i]),
            .valid_o    (cell_valid[i]),
            .gt_o       (cell_gt[i])
        );
    end

`include "assert_macros.svh"

    `AIS_ASSERT(a_no_overlap, !(s_ready && m_valid), "load and drain overlap")
    `AIS_ASSERT(a_chain_packed, cell_valid[1] |-> cell_valid[0], "gap at chain head")
    `AIS_ASSERT(a_end_reloads, (m_fire && m_run_end) |=> s_ready, "no reload after run end")
    `AIS_ASSERT(a_drain_cont, (m_fire && !m_run_end) |=> m_valid, "drain stopped early")
    `AIS_ASSERT_PAST(a_final_drains, (s_fire && s_is_final) |=> m_valid, "final gave no result")

endmodule
